// ----- rtl/core/lfisp_pkg.sv -----
// lfisp_pkg: shared types, register codes and constants of the interpolating sample packer
// no dependencies; used by lfisp_front, lfisp_back and the top level
`default_nettype none

package lfisp_pkg;

  localparam int unsigned COUNT_W     = 10;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned FRAC_SHIFT  = 18;
  localparam int unsigned OUT_DEPTH   = 8;
  localparam int unsigned MID_DEPTH   = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_AP_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LF_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN     = 2'd3;

  localparam logic [COUNT_W-1:0]  AP_COUNT_RESET = 10'd384;
  localparam logic [COUNT_W-1:0]  LF_COUNT_RESET = 10'd384;
  localparam logic [SAMPLE_W-1:0] OFFSET_RESET   = 16'h2666;
  localparam logic [SAMPLE_W-1:0] GAIN_RESET     = 16'hCAAB;

  localparam logic [SAMPLE_W-1:0] Q_POS_LIMIT = 16'd32768;
  localparam logic [SAMPLE_W-1:0] Q_NEG_LIMIT = 16'd32769;
  localparam logic [SAMPLE_W-1:0] WORD_MAX    = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] WORD_MIN    = 16'h8000;
  localparam int unsigned         SAT_MAG     = 32769;

  typedef enum logic [1:0] {
    KIND_AP,
    KIND_LF,
    KIND_SYNC
  } slot_kind_e;

  typedef struct packed {
    logic [COUNT_W-1:0]         ap_count;
    logic [COUNT_W-1:0]         lf_count;
    logic signed [SAMPLE_W-1:0] offset;
    logic signed [SAMPLE_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    slot_kind_e                 kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       eot;
    logic                       eop;
  } slot_info_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] word;
    logic                       eot;
    logic                       eop;
    logic                       sat;
  } out_word_t;

  function automatic logic [COUNT_W:0] clamp_count(logic [COUNT_W-1:0] c, int unsigned lim);
    logic [COUNT_W:0] r;
    if (c > lim) begin
      r = (COUNT_W+1)'(lim);
    end else begin
      r = {1'b0, c};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lfisp_ram.sv -----
// lfisp_ram: generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module lfisp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/lfisp_fifo.sv -----
// lfisp_fifo: small flop based fifo with occupancy count
// no dependencies; used between front and back and on the result side
`default_nettype none

module lfisp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o,
  output logic      [CW-1:0]    count_o
);

  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lfisp_front.sv -----
// lfisp_front: slot and timepoint counters, classifies each accepted sample
// depends on lfisp_pkg
`default_nettype none

module lfisp_front #(
  parameter int unsigned MAX_CHANNELS = 512,
  parameter int unsigned TIMEPOINTS   = 12,
  localparam int unsigned JW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned TW = (TIMEPOINTS > 1) ? $clog2(TIMEPOINTS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lfisp_pkg::cfg_t        cfg_i,
  input  wire logic                   accept_i,
  input  wire logic signed [15:0]     sample_i,
  output lfisp_pkg::slot_info_t       info_o,
  output logic             [JW-1:0]   chan_o,
  output logic             [TW-1:0]   tp_o
);

  localparam int unsigned CNTW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned KW   = $clog2(2 * MAX_CHANNELS + 1);
  localparam logic [TW-1:0] TP_LAST = TW'(TIMEPOINTS - 1);

  logic [KW-1:0]   slot_q, slot_d;
  logic [TW-1:0]   tp_q, tp_d;
  logic [CNTW-1:0] ap_n, lf_n;
  logic [KW-1:0]   ap_k, sync_k;
  logic            last_tp;

  assign ap_n    = CNTW'(lfisp_pkg::clamp_count(cfg_i.ap_count, MAX_CHANNELS));
  assign lf_n    = CNTW'(lfisp_pkg::clamp_count(cfg_i.lf_count, MAX_CHANNELS));
  assign ap_k    = KW'(ap_n);
  assign sync_k  = KW'(ap_n) + KW'(lf_n);
  assign last_tp = (tp_q >= TP_LAST);

  always_comb begin
    info_o.sample = sample_i;
    info_o.eot    = 1'b0;
    info_o.eop    = 1'b0;
    chan_o        = '0;
    tp_o          = tp_q;
    if (slot_q < ap_k) begin
      info_o.kind = lfisp_pkg::KIND_AP;
    end else if (slot_q < sync_k) begin
      info_o.kind = lfisp_pkg::KIND_LF;
      chan_o      = JW'(slot_q - ap_k);
    end else begin
      info_o.kind = lfisp_pkg::KIND_SYNC;
      info_o.eot  = 1'b1;
      info_o.eop  = last_tp;
    end
  end

  always_comb begin
    slot_d = slot_q;
    tp_d   = tp_q;
    if (accept_i) begin
      if (info_o.kind == lfisp_pkg::KIND_SYNC) begin
        slot_d = '0;
        tp_d   = last_tp ? '0 : tp_q + 1'b1;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      tp_q   <= '0;
    end else begin
      slot_q <= slot_d;
      tp_q   <= tp_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lfisp_back.sv -----
// lfisp_back: lf stores, scaling and interpolation pipeline, clear and copy sweeps
// depends on lfisp_pkg and lfisp_ram
`default_nettype none

module lfisp_back #(
  parameter int unsigned MAX_CHANNELS = 512,
  parameter int unsigned TIMEPOINTS   = 12,
  localparam int unsigned JW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned TW  = (TIMEPOINTS > 1) ? $clog2(TIMEPOINTS) : 1,
  localparam int unsigned OCW = $clog2(lfisp_pkg::OUT_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lfisp_pkg::cfg_t       cfg_i,
  input  wire lfisp_pkg::slot_info_t head_info_i,
  input  wire logic [JW-1:0]         head_chan_i,
  input  wire logic [TW-1:0]         head_tp_i,
  input  wire logic                  head_empty_i,
  output logic                       head_pop_o,
  input  wire logic [OCW-1:0]        out_count_i,
  output logic                       out_push_o,
  output lfisp_pkg::out_word_t       out_data_o,
  output logic                       clearing_o
);

  localparam int unsigned CNTW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned TCW  = $clog2(TIMEPOINTS + 1);
  localparam int unsigned NW   = 18 + TCW;
  localparam int unsigned PW   = NW + 16;
  localparam int unsigned XW   = PW - lfisp_pkg::FRAC_SHIFT;
  localparam int unsigned LIM  = TIMEPOINTS * lfisp_pkg::SAT_MAG;
  localparam int unsigned XCW  = $clog2(LIM + 1);
  localparam int unsigned RS   = XCW;
  localparam int unsigned RW   = RS + 1;
  localparam int unsigned PRW  = XCW + RW;

  localparam logic signed [NW-1:0] T_X   = NW'(TIMEPOINTS);
  localparam logic [XCW-1:0]       T_U   = XCW'(TIMEPOINTS);
  localparam logic [XW-1:0]        LIM_X = XW'(LIM);
  localparam logic [XCW-1:0]       LIM_C = XCW'(LIM);
  localparam logic [RW-1:0]        RECIP = RW'((2 ** RS) / TIMEPOINTS);

  // sweep control
  logic            sweep_q, sweep_d;
  logic            clear_q, clear_d;
  logic [CNTW-1:0] idx_q, idx_d;
  logic [CNTW-1:0] end_q, end_d;
  logic            copy_wr_q;
  logic [JW-1:0]   copy_addr_q;
  logic [CNTW-1:0] lf_n;
  logic            sweep_last;

  // pipeline valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [OCW:0] used;
  logic issue;

  // ram ports
  logic          pend_we, prev_we;
  logic [JW-1:0] pend_raddr, prev_waddr;
  logic [15:0]   prev_wdata, prev_rdata, pend_rdata;

  // stage payloads
  lfisp_pkg::slot_info_t s1_info_q, s2_info_q, s3_info_q, s4_info_q, s5_info_q;
  logic [TW-1:0]         s1_tp_q;
  logic signed [NW-1:0]  base_x, off_x, prev_x, pend_x, tp_x;
  logic signed [NW-1:0]  a_d, a_q, d_d, d_q;
  logic signed [PW-1:0]  p_d, p_q;
  logic [PW-1:0]         mag;
  logic [XW-1:0]         x_val;
  logic [XCW-1:0]        xc_d, xc_q, xc5_q;
  logic                  neg_d, neg4_q, neg5_q;
  logic [PRW-1:0]        prod;
  logic [15:0]           q0_d, q0_q, q_val;
  logic [XCW-1:0]        rem;

  assign lf_n       = CNTW'(lfisp_pkg::clamp_count(cfg_i.lf_count, MAX_CHANNELS));
  assign clearing_o = sweep_q && clear_q;
  assign sweep_last = ({1'b0, idx_q} + 1'b1) == {1'b0, end_q};

  assign used  = (OCW+1)'(out_count_i) + (OCW+1)'(v1_q) + (OCW+1)'(v2_q)
               + (OCW+1)'(v3_q) + (OCW+1)'(v4_q) + (OCW+1)'(v5_q);
  assign issue = !head_empty_i && !sweep_q && !copy_wr_q
               && (used < (OCW+1)'(lfisp_pkg::OUT_DEPTH));
  assign head_pop_o = issue;

  // lf stores
  assign pend_we    = issue && (head_info_i.kind == lfisp_pkg::KIND_LF) && (head_tp_i == '0);
  assign pend_raddr = sweep_q ? idx_q[JW-1:0] : head_chan_i;
  assign prev_we    = clearing_o || copy_wr_q;
  assign prev_waddr = clearing_o ? idx_q[JW-1:0] : copy_addr_q;
  assign prev_wdata = clearing_o ? '0 : pend_rdata;

  lfisp_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (head_chan_i),
    .wdata_i (head_info_i.sample),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata)
  );

  lfisp_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (head_chan_i),
    .rdata_o (prev_rdata)
  );

  always_comb begin
    sweep_d = sweep_q;
    clear_d = clear_q;
    idx_d   = idx_q;
    end_d   = end_q;
    if (sweep_q) begin
      idx_d = idx_q + 1'b1;
      if (sweep_last) begin
        sweep_d = 1'b0;
      end
    end else if (issue && head_info_i.eop && (lf_n != '0)) begin
      sweep_d = 1'b1;
      clear_d = 1'b0;
      idx_d   = '0;
      end_d   = lf_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q   <= 1'b1;
      clear_q   <= 1'b1;
      idx_q     <= '0;
      end_q     <= CNTW'(MAX_CHANNELS);
      copy_wr_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
    end else begin
      sweep_q   <= sweep_d;
      clear_q   <= clear_d;
      idx_q     <= idx_d;
      end_q     <= end_d;
      copy_wr_q <= sweep_q && !clear_q;
      v1_q      <= issue;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
    end
  end

  // stage 1: offset removal and interpolation terms
  always_comb begin
    prev_x = NW'($signed(prev_rdata));
    pend_x = NW'($signed(pend_rdata));
    off_x  = NW'(cfg_i.offset);
    tp_x   = $signed({{(NW-TW){1'b0}}, s1_tp_q});
    if (s1_info_q.kind == lfisp_pkg::KIND_AP) begin
      base_x = NW'(s1_info_q.sample);
    end else begin
      base_x = prev_x;
    end
    a_d = (base_x - off_x) * T_X;
    if ((s1_info_q.kind == lfisp_pkg::KIND_LF) && (s1_tp_q != '0)) begin
      d_d = tp_x * (pend_x - prev_x);
    end else begin
      d_d = '0;
    end
  end

  // stage 2: gain
  assign p_d = PW'(cfg_i.gain) * PW'(a_q + d_q);

  // stage 3: magnitude, fraction drop, clip
  always_comb begin
    neg_d = p_q[PW-1];
    mag   = neg_d ? PW'(-p_q) : PW'(p_q);
    x_val = mag[PW-1:lfisp_pkg::FRAC_SHIFT];
    xc_d  = (x_val > LIM_X) ? LIM_C : XCW'(x_val);
  end

  // stage 4: reciprocal estimate of the quotient
  assign prod = PRW'(xc_q) * PRW'(RECIP);
  assign q0_d = 16'(prod >> RS);

  // stage 5: correction, sign and saturation
  always_comb begin
    rem   = xc5_q - (XCW'(q0_q) * T_U);
    q_val = (rem >= T_U) ? q0_q + 16'd1 : q0_q;
    out_data_o.eot = s5_info_q.eot;
    out_data_o.eop = s5_info_q.eop;
    out_data_o.sat = 1'b0;
    if (s5_info_q.kind == lfisp_pkg::KIND_SYNC) begin
      out_data_o.word = s5_info_q.sample;
    end else if (!neg5_q) begin
      if (q_val >= lfisp_pkg::Q_POS_LIMIT) begin
        out_data_o.word = lfisp_pkg::WORD_MAX;
        out_data_o.sat  = 1'b1;
      end else begin
        out_data_o.word = q_val;
      end
    end else begin
      if (q_val >= lfisp_pkg::Q_NEG_LIMIT) begin
        out_data_o.word = lfisp_pkg::WORD_MIN;
        out_data_o.sat  = 1'b1;
      end else begin
        out_data_o.word = 16'd0 - q_val;
      end
    end
  end

  assign out_push_o = v5_q;

  always_ff @(posedge clk_i) begin
    copy_addr_q <= idx_q[JW-1:0];
    s1_info_q   <= head_info_i;
    s1_tp_q     <= head_tp_i;
    s2_info_q   <= s1_info_q;
    a_q         <= a_d;
    d_q         <= d_d;
    s3_info_q   <= s2_info_q;
    p_q         <= p_d;
    s4_info_q   <= s3_info_q;
    xc_q        <= xc_d;
    neg4_q      <= neg_d;
    s5_info_q   <= s4_info_q;
    q0_q        <= q0_d;
    xc5_q       <= xc_q;
    neg5_q      <= neg4_q;
  end

endmodule

`default_nettype wire

// ----- rtl/core/lf_interpolating_sample_packer.sv -----
// lf_interpolating_sample_packer: top level, configuration registers, queues, front and back
// depends on lfisp_pkg, lfisp_fifo, lfisp_front, lfisp_back
//
// One 16-bit input per output slot in packet order (AP slots, LF slots, sync per timepoint),
// one result word per input. The back end is a five-stage pipeline that sustains one
// transaction per cycle while the result queue has room and no sweep is running. After reset
// the previous-LF ram is cleared while full stays high. At each packet end the pending LF
// values of the clamped lf_channel_count channels are copied into the previous-LF ram; the
// back end stalls during the copy and the four-entry front queue keeps taking input until
// it fills.
`default_nettype none

module lf_interpolating_sample_packer #(
  parameter int unsigned MAX_CHANNELS = 512,
  parameter int unsigned TIMEPOINTS   = 12
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [lfisp_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire logic [lfisp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic signed [15:0]                    sample_in_i,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic signed [15:0]                         word_out_o,
  output logic                                       end_of_timepoint_o,
  output logic                                       end_of_packet_o,
  output logic                                       saturated_o
);

  localparam int unsigned JW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned TW  = (TIMEPOINTS > 1) ? $clog2(TIMEPOINTS) : 1;
  localparam int unsigned MW  = $bits(lfisp_pkg::slot_info_t) + JW + TW;
  localparam int unsigned OW  = $bits(lfisp_pkg::out_word_t);
  localparam int unsigned OCW = $clog2(lfisp_pkg::OUT_DEPTH + 1);

  lfisp_pkg::cfg_t       cfg_q, cfg_d;
  lfisp_pkg::slot_info_t fr_info, hd_info;
  lfisp_pkg::out_word_t  bk_out, out_head;
  logic [JW-1:0]         fr_chan, hd_chan;
  logic [TW-1:0]         fr_tp, hd_tp;
  logic [MW-1:0]         mid_rdata;
  logic                  mid_full, mid_empty, hd_pop, accept, clearing;
  logic                  out_push;
  logic [OW-1:0]         out_rdata;
  logic [OCW-1:0]        out_count;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        lfisp_pkg::CFG_AP_COUNT: cfg_d.ap_count = cfg_data_i[lfisp_pkg::COUNT_W-1:0];
        lfisp_pkg::CFG_LF_COUNT: cfg_d.lf_count = cfg_data_i[lfisp_pkg::COUNT_W-1:0];
        lfisp_pkg::CFG_OFFSET:   cfg_d.offset   = $signed(cfg_data_i);
        lfisp_pkg::CFG_GAIN:     cfg_d.gain     = $signed(cfg_data_i);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ap_count <= lfisp_pkg::AP_COUNT_RESET;
      cfg_q.lf_count <= lfisp_pkg::LF_COUNT_RESET;
      cfg_q.offset   <= $signed(lfisp_pkg::OFFSET_RESET);
      cfg_q.gain     <= $signed(lfisp_pkg::GAIN_RESET);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full   = mid_full || clearing;
  assign accept = push && !full;

  lfisp_front #(.MAX_CHANNELS(MAX_CHANNELS), .TIMEPOINTS(TIMEPOINTS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .sample_i (sample_in_i),
    .info_o   (fr_info),
    .chan_o   (fr_chan),
    .tp_o     (fr_tp)
  );

  lfisp_fifo #(.WIDTH(MW), .DEPTH(lfisp_pkg::MID_DEPTH)) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i ({fr_info, fr_chan, fr_tp}),
    .full_o  (mid_full),
    .pop_i   (hd_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .count_o ()
  );

  assign {hd_info, hd_chan, hd_tp} = mid_rdata;

  lfisp_back #(.MAX_CHANNELS(MAX_CHANNELS), .TIMEPOINTS(TIMEPOINTS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_info_i  (hd_info),
    .head_chan_i  (hd_chan),
    .head_tp_i    (hd_tp),
    .head_empty_i (mid_empty),
    .head_pop_o   (hd_pop),
    .out_count_i  (out_count),
    .out_push_o   (out_push),
    .out_data_o   (bk_out),
    .clearing_o   (clearing)
  );

  lfisp_fifo #(.WIDTH(OW), .DEPTH(lfisp_pkg::OUT_DEPTH)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (bk_out),
    .full_o  (),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_head           = out_rdata;
  assign word_out_o         = out_head.word;
  assign end_of_timepoint_o = out_head.eot;
  assign end_of_packet_o    = out_head.eop;
  assign saturated_o        = out_head.sat;

endmodule

`default_nettype wire
